[sv/fcbc_pkg.sv]
// Package with the shared types, constants and code tables of the byte codec.
`timescale 1ns / 1ps

package fcbc_pkg;

    typedef enum logic
    {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    localparam logic [4:0] CODE_FIRST = 5'b10000;
    localparam logic [4:0] CODE_LAST  = 5'b11101;
    localparam int         CODE_COUNT = 14;
    localparam logic [3:0] SHORT_WIDTH = 4'd5;
    localparam logic [3:0] LONG_WIDTH  = 4'd8;

    typedef struct packed
    {
        logic       hit;
        logic [3:0] idx;
    } code_hit_t;

    typedef struct packed
    {
        logic [1:0] n;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] store_next;
        logic [2:0] count_next;
    } step_t;

    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       run_end;
    } result_t;

    // Character for each short code, in code order.
    function automatic logic [7:0] code_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'd32;
            4'd1:    c = 8'd101;
            4'd2:    c = 8'd116;
            4'd3:    c = 8'd111;
            4'd4:    c = 8'd97;
            4'd5:    c = 8'd104;
            4'd6:    c = 8'd110;
            4'd7:    c = 8'd115;
            4'd8:    c = 8'd105;
            4'd9:    c = 8'd114;
            4'd10:   c = 8'd100;
            4'd11:   c = 8'd108;
            4'd12:   c = 8'd117;
            4'd13:   c = 8'd109;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic code_hit_t char_to_code(input logic [7:0] c);
        code_hit_t r;
        r.hit = 1'b0;
        r.idx = 4'd0;
        for (int i = CODE_COUNT - 1; i >= 0; i--)
        begin
            if (code_char(4'(i)) == c)
            begin
                r.hit = 1'b1;
                r.idx = 4'(i);
            end
        end
        return r;
    endfunction

endpackage

[sv/fcbc_in_if.sv]
// Handshake channel that carries input words into the codec.
`timescale 1ns / 1ps

interface fcbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

[sv/fcbc_out_if.sv]
// Handshake channel that carries result words out of the codec.
`timescale 1ns / 1ps

interface fcbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;

    modport source (output valid, output out_byte, output run_end, input ready);
    modport sink (input valid, input out_byte, input run_end, output ready);
endinterface

[sv/fixed_code_byte_codec_unit.sv]
// Top level of the fixed prefix code byte codec with input register and result queue.
//
//   Channel      Dir   Fields               Handshake
//   item         in    data_byte, last      valid/ready
//   result       out   out_byte, run_end    valid/ready
//   cfg_wr_*     in    mode (1 bit)         write enable, no ready
//
// An accepted word is held in the input register, where encode or decode runs in a
// single pass and writes zero, one or two result words into the result queue.
// A new word is taken every cycle while the queue has room for two more words, so the
// sustained rate is one word per cycle when each makes at most one result and is set by the
// one-word-per-cycle output port otherwise. Reset clears the mode to encode, the held bits,
// the input register and the queue. A stalled output fills the queue and then holds the input.
`timescale 1ns / 1ps

module fixed_code_byte_codec_unit
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    fcbc_in_if.sink           item,
    fcbc_out_if.source        result
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    fcbc_pkg::mode_t   mode_reg;
    logic              hold_valid_reg;
    logic [7:0]        hold_byte_reg;
    logic              hold_last_reg;
    logic [7:0]        bit_store_reg;
    logic [2:0]        bit_count_reg;
    fcbc_pkg::result_t queue_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_second;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;

    fcbc_pkg::step_t   step;
    logic              fire;
    logic              take;
    logic              pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FIFO_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    fcbc_core u_core
    (
        .mode      (mode_reg),
        .data_byte (hold_byte_reg),
        .last      (hold_last_reg),
        .bit_store (bit_store_reg),
        .bit_count (bit_count_reg),
        .step      (step)
    );

    assign fire       = hold_valid_reg && (fill_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign item.ready = !hold_valid_reg || fire;
    assign take       = item.valid && item.ready;

    assign result.valid    = (fill_reg != '0);
    assign result.out_byte = queue_reg[rd_ptr_reg].out_byte;
    assign result.run_end  = queue_reg[rd_ptr_reg].run_end;
    assign pop             = result.valid && result.ready;

    always_comb
    begin
        logic [CNT_W-1:0] pushed;
        pushed        = fire ? CNT_W'(step.n) : '0;
        wr_ptr_second = ptr_inc(wr_ptr_reg);
        wr_ptr_next   = wr_ptr_reg;
        if (pushed == CNT_W'(1))
        begin
            wr_ptr_next = wr_ptr_second;
        end
        else if (pushed == CNT_W'(2))
        begin
            wr_ptr_next = ptr_inc(wr_ptr_second);
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg + pushed - (pop ? CNT_W'(1) : CNT_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= fcbc_pkg::MODE_ENCODE;
            hold_valid_reg <= 1'b0;
            bit_store_reg  <= '0;
            bit_count_reg  <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= fcbc_pkg::mode_t'(cfg_wr_data);
            end
            if (take)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                bit_store_reg <= step.store_next;
                bit_count_reg <= step.count_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_byte_reg <= item.data_byte;
            hold_last_reg <= item.last;
        end
        if (fire && step.n != 2'd0)
        begin
            queue_reg[wr_ptr_reg].out_byte <= step.byte0;
            queue_reg[wr_ptr_reg].run_end  <= (step.n == 2'd1);
        end
        if (fire && step.n == 2'd2)
        begin
            queue_reg[wr_ptr_second].out_byte <= step.byte1;
            queue_reg[wr_ptr_second].run_end  <= 1'b1;
        end
    end

endmodule

[sv/fcbc_core.sv]
// Combinational encode and decode of one byte against the held bit state.
`timescale 1ns / 1ps

module fcbc_core
(
    input  fcbc_pkg::mode_t mode,
    input  logic [7:0]      data_byte,
    input  logic            last,
    input  logic [7:0]      bit_store,
    input  logic [2:0]      bit_count,
    output fcbc_pkg::step_t step
);

    fcbc_pkg::step_t enc;
    fcbc_pkg::step_t dec;

    always_comb
    begin
        fcbc_pkg::code_hit_t hit;
        logic [7:0]  code;
        logic [3:0]  width;
        logic [15:0] acc;
        logic [3:0]  total;
        enc = '0;
        hit = fcbc_pkg::char_to_code(data_byte);
        if (hit.hit)
        begin
            code  = {3'b000, fcbc_pkg::CODE_FIRST} + {4'b0000, hit.idx};
            width = fcbc_pkg::SHORT_WIDTH;
        end
        else
        begin
            code  = data_byte;
            width = fcbc_pkg::LONG_WIDTH;
        end
        acc   = ({8'd0, bit_store} << width) | {8'd0, code};
        total = {1'b0, bit_count} + width;
        if (total >= 4'd8)
        begin
            enc.byte0 = 8'(acc >> (total - 4'd8));
            enc.n     = 2'd1;
            total     = total - 4'd8;
        end
        acc = acc & ((16'd1 << total) - 16'd1);
        if (last && total != 4'd0)
        begin
            if (enc.n == 2'd0)
            begin
                enc.byte0 = 8'(acc << (4'd8 - total));
            end
            else
            begin
                enc.byte1 = 8'(acc << (4'd8 - total));
            end
            enc.n = enc.n + 2'd1;
            acc   = '0;
            total = '0;
        end
        enc.store_next = acc[7:0];
        enc.count_next = total[2:0];
    end

    always_comb
    begin
        logic [7:0] st;
        logic [3:0] cnt;
        logic [7:0] emit;
        logic       fire;
        dec  = '0;
        st   = bit_store;
        cnt  = {1'b0, bit_count};
        emit = '0;
        fire = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            st   = {st[6:0], data_byte[3'(7 - k)]};
            cnt  = cnt + 4'd1;
            fire = 1'b0;
            if (cnt == 4'd8)
            begin
                emit = st;
                fire = 1'b1;
            end
            else if (cnt == 4'd5 && st >= {3'b000, fcbc_pkg::CODE_FIRST}
                     && st <= {3'b000, fcbc_pkg::CODE_LAST})
            begin
                emit = fcbc_pkg::code_char(4'(st - {3'b000, fcbc_pkg::CODE_FIRST}));
                fire = 1'b1;
            end
            if (fire)
            begin
                if (dec.n == 2'd0)
                begin
                    dec.byte0 = emit;
                end
                else
                begin
                    dec.byte1 = emit;
                end
                dec.n = dec.n + 2'd1;
                st    = '0;
                cnt   = '0;
            end
        end
        if (last)
        begin
            st  = '0;
            cnt = '0;
        end
        dec.store_next = st;
        dec.count_next = cnt[2:0];
    end

    assign step = (mode == fcbc_pkg::MODE_DECODE) ? dec : enc;

endmodule
